>>> design/positional_insert_delete_list_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the positional insert/delete list
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_INSERT_DELETE_LIST_UNIT_ASSERT_SVH
`define POSITIONAL_INSERT_DELETE_LIST_UNIT_ASSERT_SVH

// same-cycle implication
`define PIDL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("list unit assertion failed");

// next-cycle implication
`define PIDL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("list unit assertion failed");

`endif

>>> design/pidl_pkg.sv
// ----------------------------------------------------------------------------
// pidl_pkg
// Types and codes shared by the list cells and the list top level.
// ----------------------------------------------------------------------------
package pidl_pkg;

   localparam int WORD_W  = 32;
   localparam int INDEX_W = 8;   // covers the largest supported capacity

   // request modes
   localparam logic [2:0] MODE_READ   = 3'd0;
   localparam logic [2:0] MODE_WRITE  = 3'd1;
   localparam logic [2:0] MODE_INSERT = 3'd2;
   localparam logic [2:0] MODE_DELETE = 3'd3;
   localparam logic [2:0] MODE_APPEND = 3'd4;

   // response status
   localparam logic [1:0] STATUS_DONE = 2'd0;
   localparam logic [1:0] STATUS_BAD  = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   localparam logic signed [WORD_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

   // cell operations
   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_WRITE  = 2'd1;
   localparam logic [1:0] CELL_INSERT = 2'd2;
   localparam logic [1:0] CELL_DELETE = 2'd3;

   typedef struct packed {
      logic [1:0]               op;
      logic [INDEX_W-1:0]       index;
      logic signed [WORD_W-1:0] value;
   } cell_cmd_type;

endpackage

>>> design/pidl_cell.sv
// ----------------------------------------------------------------------------
// pidl_cell
// One list slot: holds a word, loads a new value, or takes a neighbor's word
// when the list opens up (insert) or closes up (delete).
// ----------------------------------------------------------------------------
module pidl_cell #(
   parameter int INDEX = 0
) (
   input  logic                                 clock,
   input  pidl_pkg::cell_cmd_type               cmd,
   input  logic signed [pidl_pkg::WORD_W-1:0]   left_word,
   input  logic signed [pidl_pkg::WORD_W-1:0]   right_word,
   output logic signed [pidl_pkg::WORD_W-1:0]   word
);

   localparam logic [pidl_pkg::INDEX_W-1:0] MY_INDEX = pidl_pkg::INDEX_W'(INDEX);

   logic signed [pidl_pkg::WORD_W-1:0] word_ff;
   logic signed [pidl_pkg::WORD_W-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      unique case (cmd.op)
         pidl_pkg::CELL_WRITE: begin
            if (cmd.index == MY_INDEX) word_in = cmd.value;
         end
         pidl_pkg::CELL_INSERT: begin
            if (cmd.index == MY_INDEX) word_in = cmd.value;
            else if (MY_INDEX > cmd.index) word_in = left_word;
         end
         pidl_pkg::CELL_DELETE: begin
            if (MY_INDEX >= cmd.index) word_in = right_word;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

>>> design/positional_insert_delete_list_unit.sv
// ----------------------------------------------------------------------------
// positional_insert_delete_list_unit
// Response: registered when the request is taken, and valid in the cycle after.
// Throughput: one request per cycle while the response side accepts; the cell chain shifts all words at once.
// Reset: clears fill count and response valid; cell words are not cleared.
// ----------------------------------------------------------------------------
module positional_insert_delete_list_unit #(
   parameter int CAPACITY = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_mode,
   input  logic [4:0]         req_position,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_read_value,
   output logic [1:0]         rsp_status,
   output logic [5:0]         rsp_fill_count
);

`include "positional_insert_delete_list_unit_assert.svh"

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
   localparam int RD_N  = (CAPACITY < 32) ? CAPACITY : 32;

   logic [CNT_W-1:0] used_ff, used_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_read_value_ff, rsp_read_value_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [5:0]       rsp_fill_count_ff;

   pidl_pkg::cell_cmd_type cmd;
   logic signed [pidl_pkg::WORD_W-1:0] words [CAPACITY];
   logic signed [pidl_pkg::WORD_W-1:0] rd_word;
   logic fire, in_range, full;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;
   assign in_range  = CMP_W'(req_position) < CMP_W'(used_ff);
   assign full      = used_ff == CNT_W'(CAPACITY);

   // word at the requested position
   always_comb begin
      rd_word = '0;
      for (int i = 0; i < RD_N; i++) begin
         if (5'(i) == req_position) rd_word = words[i];
      end
   end

   always_comb begin
      used_in           = used_ff;
      rsp_read_value_in = '0;
      rsp_status_in     = pidl_pkg::STATUS_DONE;
      cmd.op            = pidl_pkg::CELL_HOLD;
      cmd.index         = pidl_pkg::INDEX_W'(req_position);
      cmd.value         = req_value;
      unique case (req_mode)
         pidl_pkg::MODE_READ: begin
            if (in_range) rsp_read_value_in = rd_word;
            else begin
               rsp_read_value_in = pidl_pkg::INT_MAX;
               rsp_status_in     = pidl_pkg::STATUS_BAD;
            end
         end
         pidl_pkg::MODE_WRITE: begin
            if (in_range) cmd.op = pidl_pkg::CELL_WRITE;
            else rsp_status_in = pidl_pkg::STATUS_BAD;
         end
         pidl_pkg::MODE_INSERT: begin
            if (!in_range) rsp_status_in = pidl_pkg::STATUS_BAD;
            else if (full) rsp_status_in = pidl_pkg::STATUS_FULL;
            else begin
               cmd.op  = pidl_pkg::CELL_INSERT;
               used_in = used_ff + 1'b1;
            end
         end
         pidl_pkg::MODE_DELETE: begin
            if (!in_range) rsp_status_in = pidl_pkg::STATUS_BAD;
            else begin
               cmd.op  = pidl_pkg::CELL_DELETE;
               used_in = used_ff - 1'b1;
            end
         end
         pidl_pkg::MODE_APPEND: begin
            if (full) rsp_status_in = pidl_pkg::STATUS_FULL;
            else begin
               cmd.op    = pidl_pkg::CELL_WRITE;
               cmd.index = pidl_pkg::INDEX_W'(used_ff);
               used_in   = used_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (!fire) begin
         cmd.op  = pidl_pkg::CELL_HOLD;
         used_in = used_ff;
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [pidl_pkg::WORD_W-1:0] left_w, right_w;
      if (g == 0) begin : g_first
         assign left_w = cmd.value;
      end else begin : g_mid_l
         assign left_w = words[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_w = words[g];
      end else begin : g_mid_r
         assign right_w = words[g+1];
      end
      pidl_cell #(.INDEX(g)) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .left_word  (left_w),
         .right_word (right_w),
         .word       (words[g])
      );
   end

   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_read_value_ff <= rsp_read_value_in;
         rsp_status_ff     <= rsp_status_in;
         rsp_fill_count_ff <= 6'(used_in);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_fill_count = rsp_fill_count_ff;

   `PIDL_ASSERT_NOW(a_fill_bounded, clock, reset, 1'b1, used_ff <= CNT_W'(CAPACITY))
   `PIDL_ASSERT_NEXT(a_fire_gives_rsp, clock, reset, fire, rsp_valid_ff)
   `PIDL_ASSERT_NEXT(a_count_idle, clock, reset, !fire, $stable(used_ff))
   `PIDL_ASSERT_NOW(a_full_count, clock, reset,
      rsp_valid_ff && rsp_status_ff == pidl_pkg::STATUS_FULL,
      rsp_fill_count_ff == 6'(CAPACITY))

endmodule

>>> test/positional_insert_delete_list_unit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_insert_delete_list_unit_checker
// Watches the request and response channels of the list unit, keeps its own
// copy of the list to predict every response, and compares field by field.
// ----------------------------------------------------------------------------
module positional_insert_delete_list_unit_checker #(
   parameter int CAPACITY = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [2:0]         req_mode,
   input  logic [4:0]         req_position,
   input  logic signed [31:0] req_value,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_read_value,
   input  logic [1:0]         rsp_status,
   input  logic [5:0]         rsp_fill_count,
   output int                 fail_count,
   output int                 pending_count
);

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [1:0]         status;
      logic [5:0]         fill_count;
   } list_answer_type;

   logic signed [31:0] list_words [CAPACITY];
   int                 used_words;
   list_answer_type    awaited_answers [$];

   // apply one request to the local list and return the response it must give
   function automatic list_answer_type apply_request(input logic [2:0] mode,
                                                     input logic [4:0] pos,
                                                     input logic signed [31:0] val);
      list_answer_type answer;
      logic            in_range;
      answer.read_value = '0;
      answer.status     = pidl_pkg::STATUS_DONE;
      in_range = (int'(pos) < used_words) && (int'(pos) < CAPACITY);
      case (mode)
         pidl_pkg::MODE_READ: begin
            if (in_range) begin
               answer.read_value = list_words[pos];
            end else begin
               answer.read_value = pidl_pkg::INT_MAX;
               answer.status     = pidl_pkg::STATUS_BAD;
            end
         end
         pidl_pkg::MODE_WRITE: begin
            if (in_range) list_words[pos] = val;
            else answer.status = pidl_pkg::STATUS_BAD;
         end
         pidl_pkg::MODE_INSERT: begin
            if (!in_range) begin
               answer.status = pidl_pkg::STATUS_BAD;
            end else if (used_words >= CAPACITY) begin
               answer.status = pidl_pkg::STATUS_FULL;
            end else begin
               for (int i = used_words; i > int'(pos); i--)
                  list_words[i] = list_words[i-1];
               list_words[pos] = val;
               used_words++;
            end
         end
         pidl_pkg::MODE_DELETE: begin
            if (!in_range) begin
               answer.status = pidl_pkg::STATUS_BAD;
            end else begin
               for (int i = int'(pos); i + 1 < used_words; i++)
                  list_words[i] = list_words[i+1];
               used_words--;
            end
         end
         pidl_pkg::MODE_APPEND: begin
            if (used_words >= CAPACITY) begin
               answer.status = pidl_pkg::STATUS_FULL;
            end else begin
               list_words[used_words] = val;
               used_words++;
            end
         end
         default: ;   // unused codes leave the list alone
      endcase
      answer.fill_count = used_words[5:0];
      return answer;
   endfunction

   always @(posedge clock) begin
      list_answer_type wanted;
      int              errors;
      errors = 0;
      if (reset) begin
         used_words = 0;
         awaited_answers.delete();
      end else begin
         // request first, so a same-edge response still finds its entry
         if (req_valid && req_ready)
            awaited_answers.push_back(apply_request(req_mode, req_position, req_value));
         if (rsp_valid && rsp_ready) begin
            if (awaited_answers.size() == 0) begin
               $error("response transaction with no request outstanding");
               errors++;
            end else begin
               wanted = awaited_answers.pop_front();
               if (rsp_read_value !== wanted.read_value) begin
                  $error("rsp_read_value mismatch: expected %0d, got %0d",
                         wanted.read_value, rsp_read_value);
                  errors++;
               end
               if (rsp_status !== wanted.status) begin
                  $error("rsp_status mismatch: expected %0d, got %0d",
                         wanted.status, rsp_status);
                  errors++;
               end
               if (rsp_fill_count !== wanted.fill_count) begin
                  $error("rsp_fill_count mismatch: expected %0d, got %0d",
                         wanted.fill_count, rsp_fill_count);
                  errors++;
               end
            end
         end
      end
      fail_count += errors;
      pending_count <= awaited_answers.size();
   end

endmodule

>>> test/positional_insert_delete_list_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_insert_delete_list_unit_test
// Drives the list unit with directed corner requests and then random request
// streams that grow, churn and drain the list under varied flow control.
// ----------------------------------------------------------------------------
module positional_insert_delete_list_unit_test;

   localparam int LIST_CAPACITY = 32;
   localparam int HOLD_CYCLES   = 64;
   localparam int QUIET_LIMIT   = 5000;

   localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
   localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [2:0]         req_mode = pidl_pkg::MODE_READ;
   logic [4:0]         req_position = '0;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_read_value;
   logic [1:0]         rsp_status;
   logic [5:0]         rsp_fill_count;

   int fail_count;
   int pending_count;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_ask           = 0;
   int hold_served        = 0;
   int hold_left          = 0;
   int quiet_cycles       = 0;
   int fill_guess         = 0;   // steers positions toward the live range

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   positional_insert_delete_list_unit #(
      .CAPACITY(LIST_CAPACITY)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_fill_count (rsp_fill_count)
   );

   positional_insert_delete_list_unit_checker #(
      .CAPACITY(LIST_CAPACITY)
   ) list_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_fill_count (rsp_fill_count),
      .fail_count     (fail_count),
      .pending_count  (pending_count)
   );

   // response side: random stalls, plus a long hold-off when asked
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_ask != hold_served) begin
         hold_served <= hold_ask;
         hold_left   <= HOLD_CYCLES - 1;
         rsp_ready   <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic send_request(input logic [2:0] mode, input logic [4:0] pos,
                               input logic signed [31:0] val);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_mode     <= mode;
      req_position <= pos;
      req_value    <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      case (mode)
         pidl_pkg::MODE_INSERT:
            if (pos < fill_guess && fill_guess < LIST_CAPACITY) fill_guess++;
         pidl_pkg::MODE_DELETE: if (pos < fill_guess) fill_guess--;
         pidl_pkg::MODE_APPEND: if (fill_guess < LIST_CAPACITY) fill_guess++;
         default: ;
      endcase
   endtask

   // weights are percentages; the rest goes to reads, writes and unused codes
   task automatic random_burst(input int count, input int append_w,
                               input int insert_w, input int delete_w);
      logic [2:0]         mode;
      logic [4:0]         pos;
      logic signed [31:0] val;
      int                 pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < append_w) mode = pidl_pkg::MODE_APPEND;
         else if (pick < append_w + insert_w) mode = pidl_pkg::MODE_INSERT;
         else if (pick < append_w + insert_w + delete_w) mode = pidl_pkg::MODE_DELETE;
         else if (pick < 96)
            mode = $urandom_range(1) ? pidl_pkg::MODE_READ : pidl_pkg::MODE_WRITE;
         else mode = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
         if (fill_guess > 0 && $urandom_range(9) != 0)
            pos = 5'($urandom_range(fill_guess - 1));
         else
            pos = 5'($urandom);
         case ($urandom_range(15))
            0:       val = 32'sh8000_0000;
            1:       val = 32'sh7FFF_FFFF;
            2:       val = '0;
            3:       val = -1;
            default: val = $signed($urandom);
         endcase
         send_request(mode, pos, val);
      end
   endtask

   initial begin
      int phase;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list: every positional request is out of range
      send_request(pidl_pkg::MODE_READ,   5'd0,  -1);
      send_request(pidl_pkg::MODE_WRITE,  5'd0,  -1);
      send_request(pidl_pkg::MODE_INSERT, 5'd0,  -1);
      send_request(pidl_pkg::MODE_DELETE, 5'd0,  -1);
      send_request(pidl_pkg::MODE_APPEND, 5'd31, 32'sh8000_0000);
      send_request(pidl_pkg::MODE_APPEND, 5'd0,  32'sh7FFF_FFFF);
      send_request(pidl_pkg::MODE_READ,   5'd0,  '0);
      send_request(pidl_pkg::MODE_READ,   5'd1,  '0);
      send_request(pidl_pkg::MODE_READ,   5'd2,  '0);
      send_request(pidl_pkg::MODE_WRITE,  5'd1,  '0);
      send_request(pidl_pkg::MODE_INSERT, 5'd0,  -1);
      // insert at the fill count is refused; append covers that slot
      send_request(pidl_pkg::MODE_INSERT, 5'd3,  32'sh1234_5678);
      send_request(pidl_pkg::MODE_READ,   5'd31, '0);
      send_request(pidl_pkg::MODE_DELETE, 5'd2,  '0);
      send_request(pidl_pkg::MODE_DELETE, 5'd0,  '0);
      for (int m = MODE_UNUSED_LO; m <= MODE_UNUSED_HI; m++)
         send_request(3'(m), 5'd31, -1);
      send_request(pidl_pkg::MODE_READ,   5'd0,  '0);
      send_request(pidl_pkg::MODE_DELETE, 5'd0,  '0);
      send_request(pidl_pkg::MODE_APPEND, 5'd0,  32'sh5555_5555);
      send_request(pidl_pkg::MODE_INSERT, 5'd0,  32'shAAAA_AAAA);
      send_request(pidl_pkg::MODE_READ,   5'd0,  '0);
      send_request(pidl_pkg::MODE_READ,   5'd1,  '0);

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct <= 0;  receiver_stall_pct <= 0;  end
            1: begin sender_idle_pct <= 53; receiver_stall_pct <= 0;  end
            2: begin sender_idle_pct <= 0;  receiver_stall_pct <= 53; end
            default: begin sender_idle_pct <= 35; receiver_stall_pct <= 35; end
         endcase
         // grow to full and bang on the full list, churn, then drain past empty
         random_burst(110, 50, 25, 5);
         random_burst(100, 15, 15, 15);
         random_burst(110, 5, 10, 50);
      end

      // long receiver hold-off while requests keep coming, so the unit backs up
      sender_idle_pct    <= 0;
      receiver_stall_pct <= 0;
      hold_ask           <= hold_ask + 1;
      random_burst(100, 40, 20, 10);
      hold_ask           <= hold_ask + 1;
      random_burst(100, 15, 15, 40);

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+design
design/pidl_pkg.sv
design/pidl_cell.sv
design/positional_insert_delete_list_unit.sv
test/positional_insert_delete_list_unit_checker.sv
test/positional_insert_delete_list_unit_test.sv
